@@ design/cte_pkg.sv @@
// shared types and constants for the credential table engine
// used by cte_store and credential_table_engine; no dependencies
package cte_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned CODE_BYTES  = 8;

  localparam int unsigned CODE_W  = 64;
  localparam int unsigned IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SUM_W   = CNT_W + 1;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned USED_W  = 5;

  // only the low CODE_BYTES bytes of a code take part in compare and store
  localparam logic [CODE_W-1:0] CODE_MASK =
    (CODE_BYTES >= 8) ? {CODE_W{1'b1}} : ((64'd1 << (CODE_BYTES * 8)) - 64'd1);

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_CHANGE = 2'd2,
    MODE_ACCESS = 2'd3
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef struct packed {
    logic [CODE_W-1:0] user;
    logic [CODE_W-1:0] pass;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ design/credential_table_engine.sv @@
// credential table engine: sequencer around a one-port-read, one-port-write table
// depends on cte_pkg and cte_store
// an add passes through S_ADD, a lookup on an empty table goes straight to S_RESP;
// delete, change, access read then compare each entry searched, and delete then moves each
// later entry down with a read and a write, each entry in turn through the single read port
// one request is in work at a time; input is ready again once the result word is loaded
// reset clears the fill count and the handshakes; table contents start undefined
module credential_table_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [cte_pkg::MODE_W-1:0]  mode_i,
  input  logic [cte_pkg::CODE_W-1:0]  user_code_i,
  input  logic [cte_pkg::CODE_W-1:0]  pass_code_i,
  input  logic [cte_pkg::CODE_W-1:0]  replacement_code_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cte_pkg::STAT_W-1:0]  status_o,
  output logic [cte_pkg::USED_W-1:0]  entries_used_o
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ADD      = 7'b0000010,
    S_SCAN_RD  = 7'b0000100,
    S_SCAN_CMP = 7'b0001000,
    S_SH_RD    = 7'b0010000,
    S_SH_WR    = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_e;

  state_e                      state_q, state_d;
  logic [cte_pkg::CNT_W-1:0]   count_q, count_d;
  logic [cte_pkg::IDX_W-1:0]   idx_q, idx_d;
  cte_pkg::status_e            res_q, res_d;
  cte_pkg::mode_e              mode_q, mode_d;
  logic [cte_pkg::CODE_W-1:0]  user_q, user_d;
  logic [cte_pkg::CODE_W-1:0]  pass_q, pass_d;
  logic [cte_pkg::CODE_W-1:0]  repl_q, repl_d;
  logic                        out_valid_q, out_valid_d;
  cte_pkg::status_e            status_q, status_d;
  logic [cte_pkg::USED_W-1:0]  used_q, used_d;

  cte_pkg::mem_req_t           mem_req;
  cte_pkg::entry_t             rd_entry;

  logic                        in_fire;
  logic                        out_free;
  logic                        hit;
  logic [cte_pkg::SUM_W-1:0]   nxt_idx;
  logic [cte_pkg::SUM_W-1:0]   nxt2_idx;
  logic [cte_pkg::SUM_W-1:0]   count_w;

  cte_store u_store (
    .clk_i      (clk_i),
    .req_i      (mem_req),
    .rd_entry_o (rd_entry)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign hit      = (rd_entry.user == user_q) && (rd_entry.pass == pass_q);
  assign nxt_idx  = cte_pkg::SUM_W'(idx_q) + cte_pkg::SUM_W'(1);
  assign nxt2_idx = cte_pkg::SUM_W'(idx_q) + cte_pkg::SUM_W'(2);
  assign count_w  = cte_pkg::SUM_W'(count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    res_d       = res_q;
    mode_d      = mode_q;
    user_d      = user_q;
    pass_d      = pass_q;
    repl_d      = repl_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    used_d      = used_q;

    mem_req       = '0;
    mem_req.waddr = idx_q;
    mem_req.raddr = idx_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mode_d = cte_pkg::mode_e'(mode_i);
          user_d = user_code_i & cte_pkg::CODE_MASK;
          pass_d = pass_code_i & cte_pkg::CODE_MASK;
          repl_d = replacement_code_i & cte_pkg::CODE_MASK;
          idx_d  = '0;
          if (cte_pkg::mode_e'(mode_i) == cte_pkg::MODE_ADD) begin
            state_d = S_ADD;
          end else if (count_q == '0) begin
            res_d   = cte_pkg::ST_MISS;
            state_d = S_RESP;
          end else begin
            state_d = S_SCAN_RD;
          end
        end
      end
      S_ADD: begin
        if (count_q == cte_pkg::CNT_W'(cte_pkg::MAX_ENTRIES)) begin
          res_d = cte_pkg::ST_FULL;
        end else begin
          mem_req.we          = 1'b1;
          mem_req.waddr       = count_q[cte_pkg::IDX_W-1:0];
          mem_req.wdata.user  = user_q;
          mem_req.wdata.pass  = pass_q;
          count_d             = count_q + cte_pkg::CNT_W'(1);
          res_d               = cte_pkg::ST_OK;
        end
        state_d = S_RESP;
      end
      S_SCAN_RD: begin
        mem_req.re = 1'b1;
        state_d    = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        res_d = cte_pkg::ST_OK;
        if (hit) begin
          state_d = S_RESP;
          case (mode_q)
            cte_pkg::MODE_DELETE: begin
              if (nxt_idx < count_w) begin
                state_d = S_SH_RD;
              end else begin
                count_d = count_q - cte_pkg::CNT_W'(1);
              end
            end
            cte_pkg::MODE_CHANGE: begin
              mem_req.we         = 1'b1;
              mem_req.wdata.user = user_q;
              mem_req.wdata.pass = repl_q;
            end
            default: ;
          endcase
        end else if (nxt_idx < count_w) begin
          idx_d   = nxt_idx[cte_pkg::IDX_W-1:0];
          state_d = S_SCAN_RD;
        end else begin
          res_d   = cte_pkg::ST_MISS;
          state_d = S_RESP;
        end
      end
      S_SH_RD: begin
        // fetch the entry above the hole
        mem_req.re    = 1'b1;
        mem_req.raddr = nxt_idx[cte_pkg::IDX_W-1:0];
        state_d       = S_SH_WR;
      end
      S_SH_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = rd_entry;
        idx_d         = nxt_idx[cte_pkg::IDX_W-1:0];
        if (nxt2_idx < count_w) begin
          state_d = S_SH_RD;
        end else begin
          count_d = count_q - cte_pkg::CNT_W'(1);
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = res_q;
          used_d      = cte_pkg::USED_W'(count_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    res_q    <= res_d;
    mode_q   <= mode_d;
    user_q   <= user_d;
    pass_q   <= pass_d;
    repl_q   <= repl_d;
    status_q <= status_d;
    used_q   <= used_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign entries_used_o = used_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cte_pkg::CNT_W'(cte_pkg::MAX_ENTRIES))
    else $error("fill count above table depth");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("second request taken while one is in work");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (state_q != S_IDLE) && (state_q != S_RESP))
    else $error("table write outside a working state");

  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> ($past(state_q) == S_ADD) || ($past(state_q) == S_SCAN_CMP)
                          || ($past(state_q) == S_SH_WR))
    else $error("fill count changed outside add or delete");

  a_resp_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) && out_free |=> out_valid_o && (state_q == S_IDLE))
    else $error("finished request not moved to output register");

endmodule

@@ design/cte_store.sv @@
// credential storage: one write port, one read port, registered read data
// depends on cte_pkg for the entry and request types
module cte_store (
  input  logic              clk_i,
  input  cte_pkg::mem_req_t req_i,
  output cte_pkg::entry_t   rd_entry_o
);

  cte_pkg::entry_t mem_q [cte_pkg::MAX_ENTRIES];
  cte_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read data holds between reads
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_entry_o = rd_q;

endmodule

@@ tb/tb_credential_table_engine.sv @@
`timescale 1ns / 1ps

// self-checking bench for credential_table_engine: directed then random requests,
// each result compared with a table predictor kept in a small scoreboard class
// depends on cte_pkg and the credential_table_engine rtl

typedef struct packed {
  cte_pkg::status_e           st;
  logic [cte_pkg::USED_W-1:0] used;
} outcome_t;

class cred_scoreboard;
  logic [cte_pkg::CODE_W-1:0] id_tab [cte_pkg::MAX_ENTRIES];
  logic [cte_pkg::CODE_W-1:0] pw_tab [cte_pkg::MAX_ENTRIES];
  int unsigned fill = 0;
  outcome_t owed [$];
  int errors = 0;

  function int unsigned pending();
    return owed.size();
  endfunction

  // updates the table copy and queues the outcome owed for this word
  function void note_request(cte_pkg::mode_e m, logic [cte_pkg::CODE_W-1:0] u,
                             logic [cte_pkg::CODE_W-1:0] p,
                             logic [cte_pkg::CODE_W-1:0] r);
    outcome_t o;
    logic [cte_pkg::CODE_W-1:0] uid;
    logic [cte_pkg::CODE_W-1:0] pw;
    logic [cte_pkg::CODE_W-1:0] npw;
    int unsigned hit;
    uid = u & cte_pkg::CODE_MASK;
    pw = p & cte_pkg::CODE_MASK;
    npw = r & cte_pkg::CODE_MASK;
    o.st = cte_pkg::ST_OK;
    if (m == cte_pkg::MODE_ADD) begin
      if (fill >= cte_pkg::MAX_ENTRIES) begin
        o.st = cte_pkg::ST_FULL;
      end else begin
        id_tab[fill] = uid;
        pw_tab[fill] = pw;
        fill++;
      end
    end else begin
      hit = fill;
      for (int unsigned i = 0; i < fill; i++)
        if (hit == fill && id_tab[i] == uid && pw_tab[i] == pw) hit = i;
      if (hit == fill) begin
        o.st = cte_pkg::ST_MISS;
      end else if (m == cte_pkg::MODE_DELETE) begin
        for (int unsigned j = hit; j + 1 < fill; j++) begin
          id_tab[j] = id_tab[j+1];
          pw_tab[j] = pw_tab[j+1];
        end
        fill--;
      end else if (m == cte_pkg::MODE_CHANGE) begin
        pw_tab[hit] = npw;
      end
    end
    o.used = cte_pkg::USED_W'(fill);
    owed.push_back(o);
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task check_result(logic [cte_pkg::STAT_W-1:0] st, logic [cte_pkg::USED_W-1:0] used);
    outcome_t o;
    if (owed.size() == 0) begin
      report_mismatch($sformatf("result word with none owed (status %0d)", st));
      return;
    end
    o = owed.pop_front();
    if (st !== o.st)
      report_mismatch($sformatf("status got %0d want %0d", st, o.st));
    if (used !== o.used)
      report_mismatch($sformatf("entries_used got %0d want %0d", used, o.used));
  endtask
endclass

module tb_credential_table_engine;
  localparam int DRAIN_CYC = 40;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_LEN = 75;
  localparam logic [cte_pkg::CODE_W-1:0] ZERO = '0;
  localparam logic [cte_pkg::CODE_W-1:0] ONES = '1;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [cte_pkg::MODE_W-1:0] mode_i;
  logic [cte_pkg::CODE_W-1:0] user_code_i;
  logic [cte_pkg::CODE_W-1:0] pass_code_i;
  logic [cte_pkg::CODE_W-1:0] replacement_code_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [cte_pkg::STAT_W-1:0] status_o;
  logic [cte_pkg::USED_W-1:0] entries_used_o;

  cred_scoreboard sb;
  bit quiet;
  bit hold_req;
  logic [cte_pkg::CODE_W-1:0] code_pool [8];

  credential_table_engine dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .user_code_i        (user_code_i),
    .pass_code_i        (pass_code_i),
    .replacement_code_i (replacement_code_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .entries_used_o     (entries_used_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // small pool so duplicates and repeated identifiers show up often
  function automatic logic [cte_pkg::CODE_W-1:0] pick_code();
    if ($urandom_range(0, 9) < 7) return code_pool[$urandom_range(0, 7)];
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(cte_pkg::mode_e m, logic [cte_pkg::CODE_W-1:0] u,
                              logic [cte_pkg::CODE_W-1:0] p,
                              logic [cte_pkg::CODE_W-1:0] r);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    mode_i             <= m;
    user_code_i        <= u;
    pass_code_i        <= p;
    replacement_code_i <= r;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_request(m, u, p, r);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic random_phase(int add_pct);
    cte_pkg::mode_e m;
    logic [cte_pkg::CODE_W-1:0] u;
    logic [cte_pkg::CODE_W-1:0] p;
    logic [cte_pkg::CODE_W-1:0] nr;
    int r;
    int unsigned idx;
    repeat (PHASE_LEN) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) begin
        m = cte_pkg::MODE_ADD;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          m = cte_pkg::MODE_DELETE;
        end else if (r < 70) begin
          m = cte_pkg::MODE_CHANGE;
        end else begin
          m = cte_pkg::MODE_ACCESS;
        end
      end
      u = pick_code();
      p = pick_code();
      nr = pick_code();
      if (m == cte_pkg::MODE_ADD) begin
        if (sb.fill > 0 && $urandom_range(0, 3) == 0) begin
          idx = $urandom_range(0, sb.fill - 1);
          u = sb.id_tab[idx];
          p = sb.pw_tab[idx];
        end
      end else if (sb.fill > 0 && $urandom_range(0, 99) < 75) begin
        // mostly hit a stored pair, now and then with one bit off
        idx = $urandom_range(0, sb.fill - 1);
        u = sb.id_tab[idx];
        p = sb.pw_tab[idx];
        if ($urandom_range(0, 9) == 0) begin
          idx = $urandom_range(0, cte_pkg::CODE_W - 1);
          p[idx] = ~p[idx];
        end
      end
      send_request(m, u, p, nr);
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && $urandom_range(0, 2) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1)
        sb.check_result(status_o, entries_used_o);
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = cte_pkg::MODE_ADD;
    user_code_i = '0;
    pass_code_i = '0;
    replacement_code_i = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    sb = new;
    foreach (code_pool[i]) code_pool[i] = {$urandom, $urandom};
    code_pool[0] = ZERO;
    code_pool[1] = ONES;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table: every lookup misses
    send_request(cte_pkg::MODE_ACCESS, ZERO, ZERO, ZERO);
    send_request(cte_pkg::MODE_DELETE, ONES, ONES, ZERO);
    send_request(cte_pkg::MODE_CHANGE, ZERO, ZERO, ONES);
    // duplicate pair at index 0 and 2
    send_request(cte_pkg::MODE_ADD, ZERO, ZERO, ONES);
    send_request(cte_pkg::MODE_ADD, ONES, ONES, ZERO);
    send_request(cte_pkg::MODE_ADD, ZERO, ZERO, ZERO);
    send_request(cte_pkg::MODE_ACCESS, ONES, ONES, ZERO);
    send_request(cte_pkg::MODE_ACCESS, ONES, ZERO, ZERO);
    // change acts on the first copy only, the second still grants access
    send_request(cte_pkg::MODE_CHANGE, ZERO, ZERO, ONES);
    send_request(cte_pkg::MODE_ACCESS, ZERO, ZERO, ZERO);
    send_request(cte_pkg::MODE_DELETE, ZERO, ONES, ZERO);
    repeat (cte_pkg::MAX_ENTRIES - 2) send_request(cte_pkg::MODE_ADD, {$urandom, $urandom},
                                                   {$urandom, $urandom}, ZERO);
    send_request(cte_pkg::MODE_ADD, ONES, ZERO, ZERO);
    send_request(cte_pkg::MODE_DELETE, ONES, ONES, ZERO);
    send_request(cte_pkg::MODE_DELETE, sb.id_tab[sb.fill-1], sb.pw_tab[sb.fill-1], ZERO);
    wait_drained();

    random_phase(60);
    wait_drained();
    random_phase(10);
    wait_drained();
    quiet = 1'b1;
    random_phase(70);
    quiet = 1'b0;
    wait_drained();
    // receiver holds off while words keep coming, so the input backs up
    hold_req = 1'b1;
    random_phase(10);
    wait_drained();
    random_phase(50);
    wait_drained();
    random_phase(30);
    wait_drained();

    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
